@@ design/periodic_task_scheduler_assert.svh @@
// assertion macros for the periodic task scheduler
`ifndef PERIODIC_TASK_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS

`define PSCHED_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

`define PSCHED_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define PSCHED_ASSERT_SAME(lbl, clk, rst, ante, cons)

`define PSCHED_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ design/psched_pkg.sv @@
// shared types and constants for the periodic task scheduler
package psched_pkg;

   localparam int DEF_TASKS = 8;
   localparam int IDX_IN_W  = 8;
   localparam int PERIOD_W  = 16;

   typedef enum logic [2:0] {
      CMD_TICK    = 3'd0,
      CMD_CREATE  = 3'd1,
      CMD_DELETE  = 3'd2,
      CMD_SUSPEND = 3'd3,
      CMD_RESUME  = 3'd4,
      CMD_WAIT    = 3'd5,
      CMD_DONE    = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_SUSPENDED = 2'd0,
      MODE_READY     = 2'd1,
      MODE_WAITING   = 2'd2,
      MODE_REMOVED   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_BAD_INDEX = 2'd1,
      STAT_NO_ENTRY  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic                present;
      mode_type            mode;
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W-1:0] countdown;
   } slot_type;

   typedef struct packed {
      logic [2:0]          cmd;
      logic                addr_hit;
      logic                run_hit;
      logic                entry;
      logic [PERIOD_W-1:0] period;
   } head_ctl_type;

   typedef struct packed {
      logic cand;
      logic no_entry;
   } head_res_type;

   localparam slot_type SLOT_RESET = '{
      present:   1'b0,
      mode:      MODE_SUSPENDED,
      period:    '0,
      countdown: '0
   };

endpackage

@@ design/psched_if.sv @@
// request and response channel interfaces
interface psched_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [7:0]  task_index;
   logic [15:0] period;
   logic        entry_present;

   modport source (output valid, command, task_index, period, entry_present, input ready);
   modport sink (input valid, command, task_index, period, entry_present, output ready);
endinterface

interface psched_rsp_if #(parameter int TASK_W = 4);
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic              switch_request;
   logic [TASK_W-1:0] next_task;

   modport source (output valid, status, switch_request, next_task, input ready);
   modport sink (input valid, status, switch_request, next_task, output ready);
endinterface

@@ design/periodic_task_scheduler.sv @@
// periodic task scheduler top level: slot ring, head update and control
//
//   channel   dir   fields
//   req_bus   in    command, task_index, period, entry_present
//   rsp_bus   out   status, switch_request, next_task
//
// for every item the slot ring rotates once through the head update, one slot per
// cycle, then the finish step settles the result
// reset clears every slot and sets the running task to idle
// a new item is taken while the last result waits; its own result then
// holds in the finish step until the response register frees
module periodic_task_scheduler #(
   parameter int TASKS = psched_pkg::DEF_TASKS
) (
   input logic                clock,
   input logic                reset,
   psched_req_if.sink         req_bus,
   psched_rsp_if.source       rsp_bus
);
   import psched_pkg::*;

   `include "periodic_task_scheduler_assert.svh"

   localparam int IDX_W  = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam int TASK_W = $clog2(TASKS + 1);

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    step_ff, step_in;
   logic [2:0]          cmd_ff, cmd_in;
   logic [IDX_IN_W-1:0] idx_ff, idx_in;
   logic [PERIOD_W-1:0] per_ff, per_in;
   logic                entry_ff, entry_in;
   status_type          status_ff, status_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    target_ff, target_in;
   logic [TASK_W-1:0]   running_ff, running_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic                rsp_sw_ff, rsp_sw_in;
   logic [TASK_W-1:0]   rsp_next_ff, rsp_next_in;

   logic                shift_en;
   logic                accept;
   logic                idx_bad;
   slot_type            chain [TASKS];
   slot_type            head_out;
   head_ctl_type        ctl;
   head_res_type        res;

   // slot ring: cell 0 is the head, the updated slot enters at the tail
   for (genvar k = 0; k < TASKS; k++) begin : g_cell
      slot_type cell_in;
      if (k == TASKS - 1) begin : g_tail
         assign cell_in = head_out;
      end else begin : g_mid
         assign cell_in = chain[k+1];
      end
      psched_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .slot_in  (cell_in),
         .slot_out (chain[k])
      );
   end

   assign ctl.cmd      = cmd_ff;
   assign ctl.addr_hit = (idx_ff == IDX_IN_W'(step_ff));
   assign ctl.run_hit  = (running_ff == TASK_W'(step_ff));
   assign ctl.entry    = entry_ff;
   assign ctl.period   = per_ff;

   psched_head u_head (
      .slot_in  (chain[0]),
      .ctl      (ctl),
      .slot_out (head_out),
      .res      (res)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign idx_bad       = (req_bus.task_index >= IDX_IN_W'(TASKS));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         running_ff   <= TASK_W'(TASKS);
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      per_ff        <= per_in;
      entry_ff      <= entry_in;
      status_ff     <= status_in;
      target_ff     <= target_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sw_ff     <= rsp_sw_in;
      rsp_next_ff   <= rsp_next_in;
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      per_in        = per_ff;
      entry_in      = entry_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      target_in     = target_ff;
      running_in    = running_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_sw_in     = rsp_sw_ff;
      rsp_next_in   = rsp_next_ff;
      shift_en      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in  = S_RUN;
               step_in   = '0;
               cmd_in    = req_bus.command;
               idx_in    = req_bus.task_index;
               per_in    = req_bus.period;
               entry_in  = req_bus.entry_present;
               found_in  = 1'b0;
               status_in = STAT_OK;
               case (req_bus.command)
                  CMD_CREATE: begin
                     if (idx_bad) begin
                        status_in = STAT_BAD_INDEX;
                     end else if (!req_bus.entry_present) begin
                        status_in = STAT_NO_ENTRY;
                     end
                  end
                  CMD_DELETE, CMD_SUSPEND, CMD_RESUME, CMD_WAIT: begin
                     if (idx_bad) begin
                        status_in = STAT_BAD_INDEX;
                     end
                  end
                  default: begin
                     status_in = STAT_OK;
                  end
               endcase
            end
         end
         S_RUN: begin
            shift_en = 1'b1;
            if (res.no_entry) begin
               status_in = STAT_NO_ENTRY;
            end
            if (res.cand && !found_ff) begin
               found_in  = 1'b1;
               target_in = step_ff;
            end
            if (step_ff == IDX_W'(TASKS - 1)) begin
               state_in = S_FINISH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_sw_in     = 1'b0;
               rsp_next_in   = '0;
               if (cmd_ff == CMD_TICK && found_ff) begin
                  rsp_sw_in   = 1'b1;
                  rsp_next_in = TASK_W'(target_ff);
                  running_in  = TASK_W'(target_ff);
               end else if (cmd_ff == CMD_DONE) begin
                  rsp_sw_in   = 1'b1;
                  rsp_next_in = TASK_W'(TASKS);
                  running_in  = TASK_W'(TASKS);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.switch_request = rsp_sw_ff;
   assign rsp_bus.next_task      = rsp_next_ff;

   `PSCHED_ASSERT_NEXT(a_accept_starts_walk, clock, reset, accept,
                       (state_ff == S_RUN) && (step_ff == '0))
   `PSCHED_ASSERT_SAME(a_no_switch_zero_next, clock, reset,
                       rsp_bus.valid && !rsp_bus.switch_request, rsp_bus.next_task == '0)
   `PSCHED_ASSERT_SAME(a_running_in_range, clock, reset, 1'b1, running_ff <= TASK_W'(TASKS))
   `PSCHED_ASSERT_SAME(a_busy_not_ready, clock, reset, state_ff != S_IDLE, !req_bus.ready)

endmodule

@@ design/psched_cell.sv @@
// one task slot of the rotating slot ring
module psched_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  psched_pkg::slot_type slot_in,
   output psched_pkg::slot_type slot_out
);
   import psched_pkg::*;

   slot_type slot_ff;
   slot_type slot_in_nxt;

   always_comb begin
      slot_in_nxt = shift_en ? slot_in : slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= SLOT_RESET;
      end else begin
         slot_ff <= slot_in_nxt;
      end
   end

   assign slot_out = slot_ff;

endmodule

@@ design/psched_head.sv @@
// slot update applied at the head of the ring
module psched_head (
   input  psched_pkg::slot_type     slot_in,
   input  psched_pkg::head_ctl_type ctl,
   output psched_pkg::slot_type     slot_out,
   output psched_pkg::head_res_type res
);
   import psched_pkg::*;

   logic [PERIOD_W-1:0] cd_dec;

   always_comb begin
      slot_out     = slot_in;
      res.cand     = 1'b0;
      res.no_entry = 1'b0;
      cd_dec       = slot_in.countdown - 16'd1;
      case (ctl.cmd)
         CMD_TICK: begin
            if (slot_in.present) begin
               if (slot_in.mode == MODE_READY) begin
                  res.cand = !ctl.run_hit;
               end else if (slot_in.mode == MODE_SUSPENDED) begin
                  slot_out.countdown = cd_dec;
                  if (cd_dec == '0) begin
                     slot_out.countdown = slot_in.period;
                     slot_out.mode      = MODE_READY;
                     res.cand           = 1'b1;
                  end
               end
            end
         end
         CMD_CREATE: begin
            if (ctl.addr_hit && ctl.entry) begin
               slot_out.present   = 1'b1;
               slot_out.mode      = MODE_SUSPENDED;
               slot_out.period    = ctl.period;
               slot_out.countdown = ctl.period;
            end
         end
         CMD_DELETE: begin
            if (ctl.addr_hit) begin
               if (slot_in.present) begin
                  slot_out = SLOT_RESET;
                  slot_out.mode = MODE_REMOVED;
               end else begin
                  res.no_entry = 1'b1;
               end
            end
         end
         CMD_SUSPEND: begin
            if (ctl.addr_hit) begin
               slot_out.mode = MODE_SUSPENDED;
            end
         end
         CMD_RESUME: begin
            if (ctl.addr_hit) begin
               slot_out.mode = MODE_READY;
            end
         end
         CMD_WAIT: begin
            if (ctl.addr_hit) begin
               slot_out.mode = MODE_WAITING;
            end
         end
         CMD_DONE: begin
            if (ctl.run_hit) begin
               slot_out.mode = MODE_SUSPENDED;
            end
         end
         default: begin
            slot_out = slot_in;
         end
      endcase
   end

endmodule
